// ===== rtl/kmdef_pkg.sv =====
// Shared types and constants of the key matrix debounce and event ring block.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package kmdef_pkg;

  // Input opcodes
  localparam logic [1:0] OP_ROW  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Register indexes on the config port
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_STALE    = 2'd1;
  localparam logic [1:0] REG_TYPE     = 2'd2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] STALE_RST    = 16'd100;
  localparam logic [7:0]  TYPE_RST     = 8'h02;

  localparam int KEY_ROW_STEP = 100;  // key number = (ROWS-row)*100 + col + 1
  localparam int MAX_SCAN_COLS = 10;  // width of the column field
  localparam int KEY_W = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_REP_TYPE,
    ST_REP_CNT,
    ST_REP_KH,
    ST_REP_KL,
    ST_REP_ST
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/kmdef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kmdef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_debounce_event_fifo_top.sv =====
// Key matrix scanner: per-key debounce, a millisecond clock and a small event ring.
// Depends on kmdef_pkg and kmdef_ram (key state and change time store).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item: a row sample,
//   a millisecond tick or a host read request. Ready is high only while the
//   sequencer is idle.
//   A row sample makes the sequencer walk min(COLS,10) columns, one per cycle,
//   reading the key store one column ahead, and the one shared 32-bit age
//   subtract/compare decides each key.
//   A tick advances the time, then drops stale entries from the oldest end,
//   again through the shared age unit.
//   A read request produces 2 + 3*n output beats (type, count, then key high,
//   key low, state per entry), one per cycle while out_ready_i is high; the
//   type beat is loaded into the output register from ST_REP_TYPE, the state
//   entered on accepting the request. The output register holds a beat while the
//   receiver stalls and the sequencer waits on it. The ring is empty afterwards.
//   Config (APB, pready tied high) writes the debounce time, stale age and
//   report type at byte addresses 0, 4, 8; write only while idle.
//   Reset (rst_ni low, async): all keys released and change times zero via valid
//   flops, time zero, ring empty, registers at defaults. No clearing pass.
`default_nettype none

module key_matrix_debounce_event_fifo_top #(
  parameter int ROWS       = 4,
  parameter int COLS       = 10,
  parameter int RING_DEPTH = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [1:0]                    row_i,
  input  wire logic [9:0]                    column_pressed_i,
  // report output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [7:0]                    out_byte_o,
  output logic                               last_byte_o,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kmdef_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [kmdef_pkg::DATA_W-1:0]  pwdata,
  output logic      [kmdef_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KAW   = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int NSCAN = (COLS < kmdef_pkg::MAX_SCAN_COLS) ? COLS : kmdef_pkg::MAX_SCAN_COLS;
  localparam int CW    = (NSCAN > 1) ? $clog2(NSCAN) : 1;
  localparam int RW    = $clog2(RING_DEPTH);
  localparam int NW    = $clog2(RING_DEPTH + 1);
  localparam int KW    = kmdef_pkg::KEY_W;

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] p);
    ring_inc = (p == RW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  kmdef_pkg::state_e state_q, state_d;

  logic [15:0] debounce_q, stale_q;
  logic [7:0]  type_q;

  logic [1:0]    row_q, row_d;
  logic [9:0]    bits_q, bits_d;
  logic [CW-1:0] col_q, col_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [31:0]   now_q, now_d;
  logic [RW-1:0] head_q, head_d, tail_q, tail_d;
  logic [NW-1:0] count_q, count_d;
  logic          tv_q [NKEYS];
  logic          tv_d [NKEYS];
  logic [KW-1:0] ring_key_q [RING_DEPTH];
  logic [KW-1:0] ring_key_d [RING_DEPTH];
  logic          ring_pr_q [RING_DEPTH];
  logic          ring_pr_d [RING_DEPTH];
  logic [31:0]   ring_time_q [RING_DEPTH];
  logic [31:0]   ring_time_d [RING_DEPTH];

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_load, out_free;

  logic            ram_we, ram_re;
  logic [KAW-1:0]  ram_raddr, cur_idx;
  logic [32:0]     ram_rdata;
  logic [31:0]     key_time;
  logic            key_state;
  logic [KW-1:0]   key_num;
  logic            pbit;

  // shared age unit
  logic [31:0] age_sub_b, age;
  logic [15:0] age_limit;
  logic        age_gt;

  logic cfg_we;

  // key store entry: {key down, change time}
  kmdef_ram #(
    .WIDTH (33),
    .DEPTH (NKEYS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_idx),
    .wdata_i ({pbit, now_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur_idx   = KAW'(int'(row_q) * COLS + int'(col_q));
  assign key_time  = tv_q[cur_idx] ? ram_rdata[31:0] : 32'd0;
  assign key_state = tv_q[cur_idx] & ram_rdata[32];
  assign key_num   = KW'((ROWS - int'(row_q)) * kmdef_pkg::KEY_ROW_STEP + int'(col_q) + 1);
  assign pbit      = bits_q[col_q];

  assign age_sub_b = (state_q == kmdef_pkg::ST_DROP) ? ring_time_q[tail_q] : key_time;
  assign age_limit = (state_q == kmdef_pkg::ST_DROP) ? stale_q : debounce_q;
  assign age       = now_q - age_sub_b;
  assign age_gt    = age > {16'd0, age_limit};

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == kmdef_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      kmdef_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      kmdef_pkg::REG_STALE:    prdata = {16'd0, stale_q};
      kmdef_pkg::REG_TYPE:     prdata = {24'd0, type_q};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    bits_d      = bits_q;
    col_d       = col_q;
    idx_d       = idx_q;
    now_d       = now_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    tv_d        = tv_q;
    ring_key_d  = ring_key_q;
    ring_pr_d   = ring_pr_q;
    ring_time_d = ring_time_q;
    out_load    = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cur_idx;

    unique case (state_q)
      kmdef_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            kmdef_pkg::OP_ROW: begin
              if (int'(row_i) < ROWS) begin
                ram_re    = 1'b1;
                ram_raddr = KAW'(int'(row_i) * COLS);
                row_d     = row_i;
                bits_d    = column_pressed_i;
                col_d     = '0;
                state_d   = kmdef_pkg::ST_SCAN;
              end
            end
            kmdef_pkg::OP_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = kmdef_pkg::ST_DROP;
            end
            kmdef_pkg::OP_READ: begin
              state_d = kmdef_pkg::ST_REP_TYPE;
            end
            default: ;
          endcase
        end
      end

      kmdef_pkg::ST_SCAN: begin
        if (pbit != key_state && age_gt) begin
          tv_d[cur_idx]       = 1'b1;
          ram_we              = 1'b1;
          ring_key_d[head_q]  = key_num;
          ring_pr_d[head_q]   = pbit;
          ring_time_d[head_q] = now_q;
          head_d              = ring_inc(head_q);
          if (count_q == NW'(RING_DEPTH)) begin
            tail_d = ring_inc(tail_q);  // full: overwrite oldest
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        if (col_q == CW'(NSCAN - 1)) begin
          state_d = kmdef_pkg::ST_IDLE;
        end else begin
          // prefetch next column's key entry
          ram_re    = 1'b1;
          ram_raddr = cur_idx + 1'b1;
          col_d     = col_q + 1'b1;
        end
      end

      kmdef_pkg::ST_DROP: begin
        if (count_q != '0 && age_gt) begin
          tail_d  = ring_inc(tail_q);
          count_d = count_q - 1'b1;
        end else begin
          state_d = kmdef_pkg::ST_IDLE;
        end
      end

      kmdef_pkg::ST_REP_TYPE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = type_q;
          out_last_d = 1'b0;
          idx_d      = '0;
          state_d    = kmdef_pkg::ST_REP_CNT;
        end
      end

      kmdef_pkg::ST_REP_CNT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = 8'(count_q);
          out_last_d = (count_q == '0);
          state_d    = (count_q == '0) ? kmdef_pkg::ST_IDLE : kmdef_pkg::ST_REP_KH;
        end
      end

      kmdef_pkg::ST_REP_KH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = {7'd0, ring_key_q[tail_q][KW-1]};
          out_last_d = 1'b0;
          state_d    = kmdef_pkg::ST_REP_KL;
        end
      end

      kmdef_pkg::ST_REP_KL: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = ring_key_q[tail_q][7:0];
          out_last_d = 1'b0;
          state_d    = kmdef_pkg::ST_REP_ST;
        end
      end

      kmdef_pkg::ST_REP_ST: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = {7'd0, ring_pr_q[tail_q]};
          out_last_d = (idx_q == count_q - 1'b1);
          tail_d     = ring_inc(tail_q);
          idx_d      = idx_q + 1'b1;
          if (idx_q == count_q - 1'b1) begin
            count_d = '0;
            state_d = kmdef_pkg::ST_IDLE;
          end else begin
            state_d = kmdef_pkg::ST_REP_KH;
          end
        end
      end

      default: state_d = kmdef_pkg::ST_IDLE;
    endcase

    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kmdef_pkg::ST_IDLE;
      col_q       <= '0;
      idx_q       <= '0;
      now_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      debounce_q  <= kmdef_pkg::DEBOUNCE_RST;
      stale_q     <= kmdef_pkg::STALE_RST;
      type_q      <= kmdef_pkg::TYPE_RST;
      for (int k = 0; k < NKEYS; k++) begin
        tv_q[k] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      idx_q       <= idx_d;
      now_q       <= now_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      tv_q        <= tv_d;
      if (cfg_we) begin
        unique case (paddr[3:2])
          kmdef_pkg::REG_DEBOUNCE: debounce_q <= pwdata[15:0];
          kmdef_pkg::REG_STALE:    stale_q    <= pwdata[15:0];
          kmdef_pkg::REG_TYPE:     type_q     <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    bits_q      <= bits_d;
    ring_key_q  <= ring_key_d;
    ring_pr_q   <= ring_pr_d;
    ring_time_q <= ring_time_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

endmodule

`default_nettype wire

// ===== test/key_matrix_debounce_event_fifo_top_test.sv =====
// Self-checking testbench for key_matrix_debounce_event_fifo_top.
// Runs a directed table, then random phases with varied settings, and checks every
// report beat against a local predictor. Depends on kmdef_pkg and the top level.
module key_matrix_debounce_event_fifo_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS       = 4;
  localparam int COLS       = 10;
  localparam int RING_DEPTH = 4;
  localparam int KEYS       = ROWS * COLS;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PLAN_LEN        = 25;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 24;   // longest row scan plus tick drops, with margin
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } report_beat_t;

  typedef enum logic {PLAN_ITEM, PLAN_CFG} plan_kind_e;

  typedef struct packed {
    plan_kind_e  kind;
    logic [1:0]  op;
    logic [1:0]  row;
    logic [9:0]  cols;
    logic        typed;     // report written out below instead of predicted
    logic [7:0]  rpt_type;  // expected type on typed reads, new type on settings rows
    logic [15:0] debounce;
    logic [15:0] stale;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [1:0]                     opcode_i;
  logic [1:0]                     row_i;
  logic [9:0]                     column_pressed_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [7:0]                     out_byte_o;
  logic                           last_byte_o;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [kmdef_pkg::ADDR_W-1:0]   paddr;
  logic [kmdef_pkg::DATA_W-1:0]   pwdata;
  logic [kmdef_pkg::DATA_W-1:0]   prdata;
  logic                           pready;

  key_matrix_debounce_event_fifo_top #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .RING_DEPTH (RING_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .row_i            (row_i),
    .column_pressed_i (column_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // predictor state
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_stale;
  logic [7:0]  cfg_type;
  logic        key_is_down [KEYS];
  logic [31:0] key_stamp   [KEYS];
  logic [31:0] clock_ms;
  logic [8:0]  evt_key     [RING_DEPTH];
  logic        evt_down    [RING_DEPTH];
  logic [31:0] evt_stamp   [RING_DEPTH];
  int unsigned evt_wr;
  int unsigned evt_rd;
  int unsigned evt_cnt;

  report_beat_t report_q [$];
  plan_row_t    plan [PLAN_LEN];
  logic [9:0]   last_cols [ROWS];

  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  bit          hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL key_matrix_debounce_event_fifo_top");
      $finish;
    end
  end

  function automatic void note_fail(string msg);
    if (fail_cnt < 10) $display("%s", msg);
    fail_cnt++;
  endfunction

  // Works out the report beats one accepted item causes and updates the shadow state.
  task automatic predict_report(input logic [1:0] op, input logic [1:0] r,
                                input logic [9:0] cols, input logic typed,
                                input logic [7:0] typed_type);
    int unsigned idx;
    int unsigned n;
    logic [8:0] key;
    report_beat_t beats [$];
    case (op)
      kmdef_pkg::OP_ROW: begin
        if (r < ROWS) begin
          for (int c = 0; c < COLS && c < kmdef_pkg::MAX_SCAN_COLS; c++) begin
            idx = r * COLS + c;
            if (cols[c] != key_is_down[idx] &&
                (clock_ms - key_stamp[idx]) > 32'(cfg_debounce)) begin
              key_is_down[idx] = cols[c];
              key_stamp[idx] = clock_ms;
              key = 9'((ROWS - r) * kmdef_pkg::KEY_ROW_STEP + c + 1);
              evt_key[evt_wr] = key;
              evt_down[evt_wr] = cols[c];
              evt_stamp[evt_wr] = clock_ms;
              evt_wr = (evt_wr + 1) % RING_DEPTH;
              // full ring: the oldest change is overwritten
              if (evt_cnt >= RING_DEPTH) evt_rd = (evt_rd + 1) % RING_DEPTH;
              else evt_cnt++;
            end
          end
        end
      end
      kmdef_pkg::OP_TICK: begin
        clock_ms = clock_ms + 32'd1;
        while (evt_cnt > 0 && (clock_ms - evt_stamp[evt_rd]) > 32'(cfg_stale)) begin
          evt_rd = (evt_rd + 1) % RING_DEPTH;
          evt_cnt--;
        end
      end
      kmdef_pkg::OP_READ: begin
        n = evt_cnt;
        beats.push_back('{cfg_type, 1'b0});
        beats.push_back('{8'(n), n == 0});
        for (int i = 0; i < n; i++) begin
          beats.push_back('{8'(evt_key[evt_rd] >> 8), 1'b0});
          beats.push_back('{evt_key[evt_rd][7:0], 1'b0});
          beats.push_back('{8'(evt_down[evt_rd]), i + 1 == n});
          evt_rd = (evt_rd + 1) % RING_DEPTH;
        end
        evt_cnt = 0;
        if (typed) begin
          report_q.push_back('{typed_type, 1'b0});
          report_q.push_back('{8'h00, 1'b1});
        end else begin
          foreach (beats[k]) report_q.push_back(beats[k]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [1:0] r, input logic [9:0] cols,
                           input logic typed, input logic [7:0] typed_type);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    row_i            <= r;
    column_pressed_i <= cols;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_report(op, r, cols, typed, typed_type);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    // ticks and row scans give no beat, so let the sequencer finish them
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then read it back.
  task automatic reg_write(input logic [1:0] idx, input logic [kmdef_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kmdef_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      kmdef_pkg::REG_DEBOUNCE: cfg_debounce = val[15:0];
      kmdef_pkg::REG_STALE:    cfg_stale    = val[15:0];
      kmdef_pkg::REG_TYPE:     cfg_type     = val[7:0];
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val)
      note_fail($sformatf("register %0d reads %08h, wrote %08h", idx, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] stale,
                                input logic [7:0] typ);
    wait_drained();
    reg_write(kmdef_pkg::REG_DEBOUNCE, kmdef_pkg::DATA_W'(deb));
    reg_write(kmdef_pkg::REG_STALE, kmdef_pkg::DATA_W'(stale));
    reg_write(kmdef_pkg::REG_TYPE, kmdef_pkg::DATA_W'(typ));
  endtask

  always @(posedge clk_i) begin : beat_check
    report_beat_t want;
    if (out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        note_fail($sformatf("unexpected report beat %02h last %0b", out_byte_o, last_byte_o));
      end else begin
        want = report_q.pop_front();
        if (want.data !== out_byte_o || want.is_last !== last_byte_o)
          note_fail($sformatf("report beat: expected %02h last %0b, got %02h last %0b",
                              want.data, want.is_last, out_byte_o, last_byte_o));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [1:0]  op;
    logic [1:0]  r;
    logic [9:0]  cols;
    logic [15:0] deb;
    logic [15:0] stale;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = kmdef_pkg::OP_ROW;
    row_i            = 2'd0;
    column_pressed_i = 10'h000;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    fail_cnt         = 0;
    src_gap_pct      = 20;
    sink_stall_pct   = 20;
    hold_off_req     = 1'b0;
    cfg_debounce     = kmdef_pkg::DEBOUNCE_RST;
    cfg_stale        = kmdef_pkg::STALE_RST;
    cfg_type         = kmdef_pkg::TYPE_RST;
    clock_ms         = '0;
    evt_wr           = 0;
    evt_rd           = 0;
    evt_cnt          = 0;
    for (int k = 0; k < KEYS; k++) begin
      key_is_down[k] = 1'b0;
      key_stamp[k]   = '0;
    end
    for (int k = 0; k < ROWS; k++) last_cols[k] = 10'h000;

    plan = '{
      // defaults: empty report, presses too early, unused opcode
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b1, kmdef_pkg::TYPE_RST,
        16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd0, 10'h3FF, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd3, 10'h3FF, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, OP_UNUSED,          2'd3, 10'h3FF, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b1, kmdef_pkg::TYPE_RST,
        16'd0, 16'd0},
      // no debounce, nothing goes stale: a full row overruns the ring
      '{PLAN_CFG,  kmdef_pkg::OP_ROW,  2'd0, 10'h000, 1'b0, 8'hFF, 16'd0, 16'hFFFF},
      '{PLAN_ITEM, kmdef_pkg::OP_TICK, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd0, 10'h3FF, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b1, 8'hFF, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd3, 10'h001, 1'b0, 8'h00, 16'd0, 16'd0},
      // same-ms release of column 0 is held back
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd3, 10'h200, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_TICK, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd3, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd1, 10'h155, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd2, 10'h2AA, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      // zero stale age: one tick empties the ring
      '{PLAN_CFG,  kmdef_pkg::OP_ROW,  2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd0, 10'h0F0, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_TICK, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b1, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_ROW,  2'd0, 10'h3FF, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_TICK, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0},
      '{PLAN_ITEM, kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b0, 8'h00, 16'd0, 16'd0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_CFG)
        apply_settings(plan[i].debounce, plan[i].stale, plan[i].rpt_type);
      else
        send_item(plan[i].op, plan[i].row, plan[i].cols, plan[i].typed, plan[i].rpt_type);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) begin
        deb   = 16'hFFFF;   // nothing can ever change
        stale = 16'd0;
      end else begin
        deb   = 16'($urandom_range(0, 4));
        stale = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 15));
      end
      apply_settings(deb, stale, 8'($urandom_range(255)));
      if (p == PHASES - 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        case ($urandom_range(2))
          0: src_gap_pct = 0;
          1: src_gap_pct = 15;
          default: src_gap_pct = 40;
        endcase
        case ($urandom_range(2))
          0: sink_stall_pct = 0;
          1: sink_stall_pct = 15;
          default: sink_stall_pct = 40;
        endcase
      end
      if (p == 2) begin
        // long receiver hold-off with a read in flight backs up the input
        hold_off_req = 1'b1;
        send_item(kmdef_pkg::OP_READ, 2'd0, 10'h000, 1'b0, 8'h00);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        r    = 2'($urandom_range(3));
        cols = 10'($urandom_range(1023));
        if (pick < 42) begin
          op = kmdef_pkg::OP_ROW;
          case ($urandom_range(3))
            0: ;
            1: cols = last_cols[r] ^ (10'd1 << $urandom_range(0, 9));
            2: cols = last_cols[r] ^ 10'($urandom & $urandom & 32'h3FF);
            default: cols = $urandom_range(1) ? 10'h3FF : 10'h000;
          endcase
          last_cols[r] = cols;
        end else if (pick < 76) begin
          op = kmdef_pkg::OP_TICK;
        end else if (pick < 94) begin
          op = kmdef_pkg::OP_READ;
        end else begin
          op = OP_UNUSED;
        end
        send_item(op, r, cols, 1'b0, 8'h00);
      end
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("PASS key_matrix_debounce_event_fifo_top");
    end else begin
      $display("FAIL key_matrix_debounce_event_fifo_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kmdef_pkg.sv
rtl/kmdef_ram.sv
rtl/key_matrix_debounce_event_fifo_top.sv
test/key_matrix_debounce_event_fifo_top_test.sv
